// ===== rtl/core/scc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types and constants for the strongly connected component counter.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int MaxNodes  = 64;
  localparam int MaxEdges  = 256;
  localparam int NodeW     = 6;   // node id
  localparam int EdgeAddrW = 8;   // edge store index
  localparam int EdgeCntW  = 9;   // edge count, holds MaxEdges
  localparam int CountW    = 7;   // node or component count, holds MaxNodes
  localparam int StatusW   = 2;
  localparam int StackW    = NodeW + EdgeCntW;  // {node, next edge}
  localparam int EdgeW     = 2 * NodeW;         // {from, to}
  localparam int ApbAddrW  = 3;
  localparam int ApbDataW  = 32;

  localparam logic [CountW-1:0] NodeCountReset = CountW'(MaxNodes);

  typedef enum logic [StatusW-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD2,
    ST_ROOT,
    ST_SCAN,
    ST_CHECK,
    ST_POPW,
    ST_FIN,
    ST_FINW,
    ST_RESP
  } state_e;

endpackage

// ===== rtl/core/scc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_if
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface scc_req_if import scc_pkg::*;;
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [NodeW-1:0] src_node;
  logic [NodeW-1:0] dst_node;
  logic             directed;

  modport source (output valid, req_type, src_node, dst_node, directed, input ready);
  modport sink   (input valid, req_type, src_node, dst_node, directed, output ready);
endinterface

interface scc_rsp_if import scc_pkg::*;;
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [CountW-1:0]  scc_count;

  modport source (output valid, status, scc_count, input ready);
  modport sink   (input valid, status, scc_count, output ready);
endinterface

// ===== rtl/core/scc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module scc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/core/scc_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_counter
// Edge store plus Kosaraju strongly connected component counter.
// ----------------------------------------------------------------------------
// An add-edge beat stores one edge (directed) or two (undirected) in a
// 256-entry edge RAM that persists across computes, then posts the result.
// A compute beat runs two depth-first passes. Each edge probe uses the
// single edge RAM read port: a scan state drives the address and a check
// state compares the word read. The depth-first stack and the finish order
// live in 64-entry RAMs; the node on top of the stack is held in registers.
// Only one beat is in work at a time; the result register lets the next
// beat in while a result waits.
// ----------------------------------------------------------------------------
module scc_counter import scc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  scc_req_if.sink             req_i,
  scc_rsp_if.source           rsp_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  // Configuration register: node_count at byte address 0.
  logic [CountW-1:0] node_count_q;
  logic              cfg_hit;

  assign cfg_hit = (paddr[ApbAddrW-1] == 1'b0);
  assign pready  = 1'b1;
  assign prdata  = cfg_hit ? ApbDataW'(node_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NodeCountReset;
    end else if (psel && penable && pwrite && cfg_hit) begin
      node_count_q <= pwdata[CountW-1:0];
    end
  end

  // Control and walk state.
  state_e               state_q, state_d;
  logic [EdgeCntW-1:0]  edge_total_q, edge_total_d;
  logic [CountW-1:0]    walk_top_q, walk_top_d;
  logic [CountW-1:0]    finish_top_q, finish_top_d;
  logic [CountW-1:0]    root_q, root_d;
  logic [CountW-1:0]    count_q, count_d;
  logic                 pass_q, pass_d;       // 0 forward pass, 1 reversed pass
  logic [MaxNodes-1:0]  seen1_q, seen1_d;
  logic [MaxNodes-1:0]  seen2_q, seen2_d;
  logic                 out_valid_q, out_valid_d;
  // Payload registers.
  logic [NodeW-1:0]     cur_node_q, cur_node_d;
  logic [EdgeCntW-1:0]  cur_next_q, cur_next_d;
  logic [NodeW-1:0]     pend_u_q, pend_u_d, pend_v_q, pend_v_d;
  logic [StatusW-1:0]   res_status_q, res_status_d;
  logic [StatusW-1:0]   out_status_q, out_status_d;
  logic [CountW-1:0]    out_count_q, out_count_d;

  // RAM ports.
  logic                 edge_we;
  logic [EdgeAddrW-1:0] edge_waddr, edge_raddr;
  logic [EdgeW-1:0]     edge_wdata, edge_rdata;
  logic                 stk_we;
  logic [NodeW-1:0]     stk_waddr, stk_raddr;
  logic [StackW-1:0]    stk_wdata, stk_rdata;
  logic                 fin_we;
  logic [NodeW-1:0]     fin_waddr, fin_raddr;
  logic [NodeW-1:0]     fin_wdata, fin_rdata;

  scc_ram #(.Width(EdgeW), .Depth(MaxEdges)) u_edge_ram (
    .clk_i, .we_i(edge_we), .waddr_i(edge_waddr), .wdata_i(edge_wdata),
    .raddr_i(edge_raddr), .rdata_o(edge_rdata)
  );

  scc_ram #(.Width(StackW), .Depth(MaxNodes)) u_stack_ram (
    .clk_i, .we_i(stk_we), .waddr_i(stk_waddr), .wdata_i(stk_wdata),
    .raddr_i(stk_raddr), .rdata_o(stk_rdata)
  );

  scc_ram #(.Width(NodeW), .Depth(MaxNodes)) u_finish_ram (
    .clk_i, .we_i(fin_we), .waddr_i(fin_waddr), .wdata_i(fin_wdata),
    .raddr_i(fin_raddr), .rdata_o(fin_rdata)
  );

  logic               req_fire;
  logic [CountW-1:0]  roots;
  logic [EdgeCntW:0]  edge_need;
  logic [NodeW-1:0]   edge_a, edge_b;
  logic               b_seen;

  assign req_i.ready   = (state_q == ST_IDLE);
  assign req_fire      = req_i.valid && req_i.ready;
  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.status  = out_status_q;
  assign rsp_o.scc_count = out_count_q;

  // Roots limited to the node space.
  assign roots     = (node_count_q > CountW'(MaxNodes)) ? CountW'(MaxNodes) : node_count_q;
  assign edge_need = {1'b0, edge_total_q} + (req_i.directed ? (EdgeCntW+1)'(1)
                                                            : (EdgeCntW+1)'(2));
  // Reversed pass follows edges backwards.
  assign edge_a = pass_q ? edge_rdata[NodeW-1:0]     : edge_rdata[EdgeW-1:NodeW];
  assign edge_b = pass_q ? edge_rdata[EdgeW-1:NodeW] : edge_rdata[NodeW-1:0];
  assign b_seen = pass_q ? seen2_q[edge_b] : seen1_q[edge_b];

  always_comb begin
    state_d      = state_q;
    edge_total_d = edge_total_q;
    walk_top_d   = walk_top_q;
    finish_top_d = finish_top_q;
    root_d       = root_q;
    count_d      = count_q;
    pass_d       = pass_q;
    seen1_d      = seen1_q;
    seen2_d      = seen2_q;
    out_valid_d  = out_valid_q;
    cur_node_d   = cur_node_q;
    cur_next_d   = cur_next_q;
    pend_u_d     = pend_u_q;
    pend_v_d     = pend_v_q;
    res_status_d = res_status_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    edge_we      = 1'b0;
    edge_waddr   = edge_total_q[EdgeAddrW-1:0];
    edge_wdata   = {req_i.src_node, req_i.dst_node};
    edge_raddr   = cur_next_q[EdgeAddrW-1:0];
    stk_we       = 1'b0;
    stk_waddr    = NodeW'(walk_top_q - CountW'(1));
    stk_wdata    = {cur_node_q, cur_next_q + EdgeCntW'(1)};
    stk_raddr    = NodeW'(walk_top_q - CountW'(2));
    fin_we       = 1'b0;
    fin_waddr    = finish_top_q[NodeW-1:0];
    fin_wdata    = cur_node_q;
    fin_raddr    = NodeW'(finish_top_q - CountW'(1));

    // Drop the result beat once taken.
    if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          count_d      = '0;
          res_status_d = STATUS_OK;
          if (req_i.req_type) begin
            seen1_d      = '0;
            seen2_d      = '0;
            finish_top_d = '0;
            walk_top_d   = '0;
            root_d       = '0;
            pass_d       = 1'b0;
            state_d      = ST_ROOT;
          end else if (int'(req_i.src_node) >= MaxNodes ||
                       int'(req_i.dst_node) >= MaxNodes) begin
            res_status_d = STATUS_RANGE;
            state_d      = ST_RESP;
          end else if (edge_need > (EdgeCntW+1)'(MaxEdges)) begin
            res_status_d = STATUS_FULL;
            state_d      = ST_RESP;
          end else begin
            edge_we      = 1'b1;
            edge_total_d = edge_total_q + EdgeCntW'(1);
            pend_u_d     = req_i.src_node;
            pend_v_d     = req_i.dst_node;
            state_d      = req_i.directed ? ST_RESP : ST_ADD2;
          end
        end
      end

      ST_ADD2: begin
        // Store the reverse edge of an undirected pair.
        edge_we      = 1'b1;
        edge_wdata   = {pend_v_q, pend_u_q};
        edge_total_d = edge_total_q + EdgeCntW'(1);
        state_d      = ST_RESP;
      end

      ST_ROOT: begin
        if (root_q < roots) begin
          root_d = root_q + CountW'(1);
          if (!seen1_q[root_q[NodeW-1:0]]) begin
            seen1_d[root_q[NodeW-1:0]] = 1'b1;
            cur_node_d = root_q[NodeW-1:0];
            cur_next_d = '0;
            walk_top_d = CountW'(1);
            state_d    = ST_SCAN;
          end
        end else begin
          pass_d  = 1'b1;
          state_d = ST_FIN;
        end
      end

      ST_SCAN: begin
        if (cur_next_q < edge_total_q) begin
          state_d = ST_CHECK;
        end else begin
          // Top node finished: pop it.
          if (!pass_q && finish_top_q < CountW'(MaxNodes)) begin
            fin_we       = 1'b1;
            finish_top_d = finish_top_q + CountW'(1);
          end
          walk_top_d = walk_top_q - CountW'(1);
          if (walk_top_q == CountW'(1)) begin
            state_d = pass_q ? ST_FIN : ST_ROOT;
          end else begin
            state_d = ST_POPW;
          end
        end
      end

      ST_CHECK: begin
        if (edge_a == cur_node_q && !b_seen && walk_top_q < CountW'(MaxNodes)) begin
          // Push the current node with its resume point, descend into b.
          stk_we     = 1'b1;
          if (pass_q) begin
            seen2_d[edge_b] = 1'b1;
          end else begin
            seen1_d[edge_b] = 1'b1;
          end
          cur_node_d = edge_b;
          cur_next_d = '0;
          walk_top_d = walk_top_q + CountW'(1);
        end else begin
          cur_next_d = cur_next_q + EdgeCntW'(1);
        end
        state_d = ST_SCAN;
      end

      ST_POPW: begin
        cur_node_d = stk_rdata[StackW-1:EdgeCntW];
        cur_next_d = stk_rdata[EdgeCntW-1:0];
        state_d    = ST_SCAN;
      end

      ST_FIN: begin
        if (finish_top_q != '0) begin
          finish_top_d = finish_top_q - CountW'(1);
          state_d      = ST_FINW;
        end else begin
          state_d = ST_RESP;
        end
      end

      ST_FINW: begin
        if (!seen2_q[fin_rdata]) begin
          seen2_d[fin_rdata] = 1'b1;
          cur_node_d = fin_rdata;
          cur_next_d = '0;
          walk_top_d = CountW'(1);
          count_d    = count_q + CountW'(1);
          state_d    = ST_SCAN;
        end else begin
          state_d = ST_FIN;
        end
      end

      ST_RESP: begin
        // Post the result once the output register is free.
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_count_d  = count_q;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      edge_total_q <= '0;
      walk_top_q   <= '0;
      finish_top_q <= '0;
      root_q       <= '0;
      count_q      <= '0;
      pass_q       <= 1'b0;
      seen1_q      <= '0;
      seen2_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      edge_total_q <= edge_total_d;
      walk_top_q   <= walk_top_d;
      finish_top_q <= finish_top_d;
      root_q       <= root_d;
      count_q      <= count_d;
      pass_q       <= pass_d;
      seen1_q      <= seen1_d;
      seen2_q      <= seen2_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_node_q   <= cur_node_d;
    cur_next_q   <= cur_next_d;
    pend_u_q     <= pend_u_d;
    pend_v_q     <= pend_v_d;
    res_status_q <= res_status_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
  end

  // The walk stack never grows past the node space.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_top_q <= CountW'(MaxNodes))
    else $error("walk stack overflow");

  // The edge store never holds more than its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, edge_total_q} <= (EdgeCntW+1)'(MaxEdges))
    else $error("edge store overflow");

  // A walk in progress always has a node on the stack.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN || state_q == ST_CHECK) |-> walk_top_q != '0)
    else $error("scan with empty walk stack");

  // A result is posted only while the output register is free or drains.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESP && out_valid_q && !rsp_o.ready) |=> state_q == ST_RESP)
    else $error("result posted over a pending beat");

endmodule
